// ===== rtl/kdns_pkg.sv =====
package kdns_pkg;

    localparam int IDX_BITS  = 10;
    localparam int CRD_BITS  = 16;
    localparam int DIST_BITS = 33;

    typedef struct packed {
        logic                       command;
        logic [IDX_BITS-1:0]        node_index;
        logic signed [CRD_BITS-1:0] coord_x;
        logic signed [CRD_BITS-1:0] coord_y;
        logic                       split_axis;
        logic [IDX_BITS-1:0]        left_child;
        logic                       left_present;
        logic [IDX_BITS-1:0]        right_child;
        logic                       right_present;
    } in_item_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]  nearest_index;
        logic [DIST_BITS-1:0] best_sq_distance;
    } out_item_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_START,
        ST_DESC_RD,
        ST_DESC_SQ,
        ST_DESC_UPD,
        ST_POP_RD,
        ST_BACK_RD,
        ST_BACK_DEC,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic write_node;
        logic start;
        logic node_rd;
        logic desc_sq;
        logic desc_upd;
        logic back_rd;
        logic back_dec;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic root_ok;
        logic cur_present;
        logic visits_full;
        logic stack_nonempty;
        logic best_valid;
    } stat_t;

endpackage

// ===== rtl/kd_tree_nearest_search_top.sv =====
// Write transaction: node stored in the cycle after acceptance, then back to
// idle for the next acceptance; no result.
// Query: each visited node takes a table read, squares, compare and push, and
// each backtrack decision a stack read, table read and plane test; m_valid rises
// once the output register is free, unless no node was visited; then back to idle.
// One transaction at a time; a result waits in the output register.
// aresetn (synchronous, active low) clears control, root_node to 0.
module kd_tree_nearest_search_top #(
    parameter int MAX_NODES  = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kdns_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output kdns_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [kdns_pkg::IDX_BITS-1:0] cfg_wdata
);

    logic [kdns_pkg::IDX_BITS-1:0] root_reg;
    kdns_pkg::cmd_t  cmd;
    kdns_pkg::stat_t st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_we) begin
            root_reg <= cfg_wdata;
        end
    end

    kdns_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .st, .cmd
    );

    kdns_dp #(.MAX_NODES(MAX_NODES), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk, .aresetn, .s_data, .root_node(root_reg), .cmd, .st, .m_data
    );

endmodule

// ===== rtl/kdns_ctrl.sv =====
module kdns_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  kdns_pkg::stat_t st,
    output kdns_pkg::cmd_t  cmd
);

    kdns_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == kdns_pkg::ST_IDLE);
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kdns_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kdns_pkg::ST_IDLE:
                if (s_valid) state_next = kdns_pkg::ST_WRITE;
            kdns_pkg::ST_WRITE:
                state_next = st.is_query ? kdns_pkg::ST_START : kdns_pkg::ST_IDLE;
            kdns_pkg::ST_START:
                state_next = st.root_ok ? kdns_pkg::ST_DESC_RD : kdns_pkg::ST_DONE;
            kdns_pkg::ST_DESC_RD, kdns_pkg::ST_POP_RD: begin
                if (st.cur_present && !st.visits_full) begin
                    state_next = kdns_pkg::ST_DESC_SQ;
                end else if (st.cur_present || st.stack_nonempty) begin
                    state_next = kdns_pkg::ST_BACK_RD;
                end else begin
                    state_next = kdns_pkg::ST_DONE;
                end
            end
            kdns_pkg::ST_DESC_SQ:  state_next = kdns_pkg::ST_DESC_UPD;
            kdns_pkg::ST_DESC_UPD: state_next = kdns_pkg::ST_POP_RD;
            kdns_pkg::ST_BACK_RD:  state_next = kdns_pkg::ST_BACK_DEC;
            kdns_pkg::ST_BACK_DEC: state_next = kdns_pkg::ST_POP_RD;
            kdns_pkg::ST_DONE:
                state_next = st.best_valid ? kdns_pkg::ST_OUT : kdns_pkg::ST_IDLE;
            kdns_pkg::ST_OUT:
                if (!out_valid_reg || m_ready) state_next = kdns_pkg::ST_IDLE;
            default: state_next = kdns_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            kdns_pkg::ST_IDLE:     cmd.load_item = s_valid;
            kdns_pkg::ST_WRITE:    cmd.write_node = !st.is_query;
            kdns_pkg::ST_START:    cmd.start = 1'b1;
            kdns_pkg::ST_DESC_RD, kdns_pkg::ST_POP_RD: cmd.node_rd = 1'b1;
            kdns_pkg::ST_DESC_SQ:  cmd.desc_sq = 1'b1;
            kdns_pkg::ST_DESC_UPD: cmd.desc_upd = 1'b1;
            kdns_pkg::ST_BACK_RD:  cmd.back_rd = 1'b1;
            kdns_pkg::ST_BACK_DEC: cmd.back_dec = 1'b1;
            kdns_pkg::ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/kdns_dp.sv =====
module kdns_dp #(
    parameter int MAX_NODES  = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kdns_pkg::in_item_t  s_data,
    input  logic [kdns_pkg::IDX_BITS-1:0] root_node,
    input  kdns_pkg::cmd_t      cmd,
    output kdns_pkg::stat_t     st,
    output kdns_pkg::out_item_t m_data
);

    localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CB  = COORD_BITS;
    localparam int DB  = 2 * CB + 1;
    localparam int NW  = 2 * CB + 1 + 2 * (AW + 1);
    localparam int SQW = 2 * CB + 2;

    logic [NW-1:0]  node_mem [MAX_NODES];
    logic [AW-1:0]  stack_mem [MAX_NODES];

    kdns_pkg::in_item_t item_reg;
    logic signed [CB-1:0] qx, qy;
    assign qx = item_reg.coord_x[CB-1:0];
    assign qy = item_reg.coord_y[CB-1:0];

    logic [AW:0]    cur_reg;
    logic           cur_pres_reg;
    logic [AW:0]    last_reg;
    logic           last_pres_reg;
    logic [AW:0]    depth_reg;
    logic [AW:0]    visits_reg;
    logic [DB-1:0]  best_dist_reg;
    logic           best_valid_reg;
    logic [AW-1:0]  best_idx_reg;
    logic [NW-1:0]  rd_reg;
    logic [AW-1:0]  top_reg;
    logic [SQW-1:0] sqa_reg, sqb_reg;
    kdns_pkg::out_item_t out_reg;

    logic visits_full_w;
    assign visits_full_w = (visits_reg == (AW+1)'(MAX_NODES));

    function automatic logic [AW:0] mk_link(logic [kdns_pkg::IDX_BITS-1:0] idx, logic p);
        logic ok;
        ok = p && ({22'd0, idx} < 32'(MAX_NODES));
        return {ok, AW'(idx)};
    endfunction

    logic signed [CB-1:0] n_px, n_py;
    logic                 n_ax;
    logic [AW:0]          n_lo, n_hi;
    assign {n_px, n_py, n_ax, n_lo, n_hi} = rd_reg;

    logic signed [CB-1:0] q_ax, p_ax;
    assign q_ax = n_ax ? qy : qx;
    assign p_ax = n_ax ? n_py : n_px;
    logic q_le_p;
    assign q_le_p = q_ax <= p_ax;

    logic [CB:0] ddx, ddy, dda;
    function automatic logic [CB:0] absdiff(logic signed [CB-1:0] a, logic signed [CB-1:0] b);
        logic signed [CB:0] d;
        d = {a[CB-1], a} - {b[CB-1], b};
        return d[CB] ? (CB+1)'(-d) : d;
    endfunction
    assign ddx = absdiff(qx, n_px);
    assign ddy = absdiff(qy, n_py);
    assign dda = absdiff(p_ax, q_ax);

    logic [DB-1:0] dsum;
    assign dsum = DB'(sqa_reg) + DB'(sqb_reg);

    logic [AW:0] far_link;
    assign far_link = q_le_p ? n_hi : n_lo;

    always_ff @(posedge aclk) begin
        if (cmd.write_node && ({22'd0, item_reg.node_index} < 32'(MAX_NODES))) begin
            node_mem[AW'(item_reg.node_index)] <= {item_reg.coord_x[CB-1:0],
                item_reg.coord_y[CB-1:0], item_reg.split_axis,
                mk_link(item_reg.left_child, item_reg.left_present),
                mk_link(item_reg.right_child, item_reg.right_present)};
        end
        if (cmd.node_rd) begin
            rd_reg <= node_mem[cur_reg[AW-1:0]];
        end
        if (cmd.back_rd) begin
            rd_reg <= node_mem[top_reg];
        end
        if (cmd.desc_upd) begin
            stack_mem[depth_reg[AW-1:0]] <= cur_reg[AW-1:0];
        end
        top_reg <= stack_mem[AW'(depth_reg - 1'b1)];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) item_reg <= s_data;
        if (cmd.desc_sq) begin
            sqa_reg <= SQW'(ddx * ddx);
            sqb_reg <= SQW'(ddy * ddy);
        end
        if (cmd.finish) begin
            out_reg.nearest_index    <= kdns_pkg::IDX_BITS'(best_idx_reg);
            out_reg.best_sq_distance <= kdns_pkg::DIST_BITS'(best_dist_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_pres_reg   <= 1'b0;
            last_pres_reg  <= 1'b0;
            depth_reg      <= '0;
            visits_reg     <= '0;
            best_valid_reg <= 1'b0;
        end else if (cmd.start) begin
            cur_reg        <= {1'b0, AW'(root_node)};
            cur_pres_reg   <= ({22'd0, root_node} < 32'(MAX_NODES));
            last_pres_reg  <= 1'b0;
            depth_reg      <= '0;
            visits_reg     <= '0;
            best_valid_reg <= 1'b0;
            best_dist_reg  <= '0;
            best_idx_reg   <= '0;
        end else if (cmd.node_rd && cur_pres_reg && visits_full_w) begin
            last_reg      <= cur_reg;
            last_pres_reg <= 1'b1;
            cur_pres_reg  <= 1'b0;
        end else if (cmd.desc_upd) begin
            visits_reg <= visits_reg + 1'b1;
            depth_reg  <= depth_reg + 1'b1;
            if (!best_valid_reg || dsum < best_dist_reg) begin
                best_valid_reg <= 1'b1;
                best_dist_reg  <= dsum;
                best_idx_reg   <= cur_reg[AW-1:0];
            end
            cur_reg       <= q_le_p ? n_lo : n_hi;
            cur_pres_reg  <= q_le_p ? n_lo[AW] : n_hi[AW];
            last_pres_reg <= 1'b0;
        end else if (cmd.back_dec) begin
            if (!(last_pres_reg == far_link[AW] &&
                  (!far_link[AW] || last_reg[AW-1:0] == far_link[AW-1:0])) &&
                (DB'(dda * dda) < best_dist_reg)) begin
                last_reg      <= far_link;
                last_pres_reg <= far_link[AW];
                cur_reg       <= far_link;
                cur_pres_reg  <= far_link[AW];
            end else begin
                depth_reg     <= depth_reg - 1'b1;
                last_reg      <= {1'b0, top_reg};
                last_pres_reg <= 1'b1;
                cur_pres_reg  <= 1'b0;
            end
        end
    end

    assign st.is_query       = (item_reg.command == kdns_pkg::CMD_QUERY);
    assign st.root_ok        = ({22'd0, root_node} < 32'(MAX_NODES));
    assign st.cur_present    = cur_pres_reg;
    assign st.visits_full    = visits_full_w;
    assign st.stack_nonempty = (depth_reg != '0);
    assign st.best_valid     = best_valid_reg;
    assign m_data            = out_reg;

endmodule
